FILE: rtl/marching_tetrahedra_cell_assert.svh
// Assertion macros shared by the front and back modules.
`ifndef MARCHING_TETRAHEDRA_CELL_ASSERT_SVH
`define MARCHING_TETRAHEDRA_CELL_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define MTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/mtc_pkg.sv
`timescale 1ns / 1ps
package mtc_pkg;
  localparam int GridSizeDef = 64;
  localparam int FracBitsDef = 8;
  localparam int CoordW = 6;
  localparam int SampleW = 16;
  localparam int DiffW = 17;
  localparam int OutW = 14;
  localparam int QueueDepth = 2;

  typedef logic signed [DiffW-1:0] diff_t;

  // A classified cell as handed from front to back.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [7:0][DiffW-1:0] d;
    logic [7:0] neg;
  } cell_t;

  function automatic logic [5:0] cut_edges(input logic [3:0] idx);
    logic [5:0] r;
    case (idx)
      4'd0, 4'd15: r = 6'h00;
      4'd1, 4'd14: r = 6'h0D;
      4'd2, 4'd13: r = 6'h13;
      4'd3, 4'd12: r = 6'h1E;
      4'd4, 4'd11: r = 6'h26;
      4'd5, 4'd10: r = 6'h2B;
      4'd6, 4'd9:  r = 6'h35;
      default:     r = 6'h38;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tri_count(input logic [3:0] idx);
    logic [1:0] r;
    case (idx)
      4'd0, 4'd15: r = 2'd0;
      4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12: r = 2'd2;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  // Edge numbers of up to two triangles; the first triangle is in the low half.
  function automatic logic [5:0][2:0] tri_edges(input logic [3:0] idx);
    logic [5:0][2:0] r;
    case (idx)
      4'd1:  r = {3'd0, 3'd0, 3'd0, 3'd2, 3'd3, 3'd0};
      4'd2:  r = {3'd0, 3'd0, 3'd0, 3'd4, 3'd1, 3'd0};
      4'd3:  r = {3'd2, 3'd3, 3'd1, 3'd3, 3'd4, 3'd1};
      4'd4:  r = {3'd0, 3'd0, 3'd0, 3'd5, 3'd2, 3'd1};
      4'd5:  r = {3'd3, 3'd0, 3'd1, 3'd5, 3'd3, 3'd1};
      4'd6:  r = {3'd0, 3'd4, 3'd2, 3'd4, 3'd5, 3'd2};
      4'd7:  r = {3'd0, 3'd0, 3'd0, 3'd4, 3'd5, 3'd3};
      4'd8:  r = {3'd0, 3'd0, 3'd0, 3'd5, 3'd4, 3'd3};
      4'd9:  r = {3'd4, 3'd0, 3'd2, 3'd5, 3'd4, 3'd2};
      4'd10: r = {3'd0, 3'd3, 3'd1, 3'd3, 3'd5, 3'd1};
      4'd11: r = {3'd0, 3'd0, 3'd0, 3'd2, 3'd5, 3'd1};
      4'd12: r = {3'd3, 3'd2, 3'd1, 3'd4, 3'd3, 3'd1};
      4'd13: r = {3'd0, 3'd0, 3'd0, 3'd1, 3'd4, 3'd0};
      4'd14: r = {3'd0, 3'd0, 3'd0, 3'd3, 3'd2, 3'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0][2:0] tet_corners(input logic [2:0] t);
    logic [3:0][2:0] r;
    case (t)
      3'd0: r = {3'd5, 3'd1, 3'd3, 3'd0};
      3'd1: r = {3'd5, 3'd2, 3'd3, 3'd1};
      3'd2: r = {3'd3, 3'd7, 3'd5, 3'd4};
      3'd3: r = {3'd3, 3'd7, 3'd6, 3'd5};
      3'd4: r = {3'd3, 3'd4, 3'd5, 3'd0};
      default: r = {3'd3, 3'd6, 3'd2, 3'd5};
    endcase
    return r;
  endfunction

  // Edge ends as tetrahedron vertex slots: {b, a}.
  function automatic logic [1:0][1:0] edge_ends(input logic [2:0] e);
    logic [1:0][1:0] r;
    case (e)
      3'd0: r = {2'd1, 2'd0};
      3'd1: r = {2'd2, 2'd1};
      3'd2: r = {2'd0, 2'd2};
      3'd3: r = {2'd3, 2'd0};
      3'd4: r = {2'd3, 2'd1};
      default: r = {2'd3, 2'd2};
    endcase
    return r;
  endfunction

  // Corner offset bits {z, y, x}.
  function automatic logic [2:0] corner_off(input logic [2:0] c);
    logic [2:0] r;
    case (c)
      3'd0: r = 3'b000;
      3'd1: r = 3'b001;
      3'd2: r = 3'b011;
      3'd3: r = 3'b010;
      3'd4: r = 3'b100;
      3'd5: r = 3'b101;
      3'd6: r = 3'b111;
      default: r = 3'b110;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/mtc_front.sv
`timescale 1ns / 1ps
module mtc_front
  import mtc_pkg::*;
#(
  parameter int GRID_SIZE = GridSizeDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic signed [SampleW-1:0] cfg_iso_level,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CoordW-1:0]         in_cell_x,
  input  logic [CoordW-1:0]         in_cell_y,
  input  logic [CoordW-1:0]         in_cell_z,
  input  logic [7:0][SampleW-1:0]   in_samples,
  output logic                      q_valid,
  input  logic                      q_pop,
  output cell_t                     q_head
);
  `include "marching_tetrahedra_cell_assert.svh"

  localparam int CoordMax = GRID_SIZE - 2;
  localparam int CntW = $clog2(QueueDepth + 1);

  logic signed [SampleW-1:0] iso_r;
  cell_t       q_mem_r [QueueDepth];
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic        in_fire, in_keep, push;
  cell_t       cls;

  always_comb begin
    cls.x = in_cell_x;
    cls.y = in_cell_y;
    cls.z = in_cell_z;
    for (int i = 0; i < 8; i++) begin
      cls.d[i] = DiffW'($signed(in_samples[i])) - DiffW'(iso_r);
      cls.neg[i] = cls.d[i][DiffW-1];
    end
  end

  assign in_stall = (cnt_r == CntW'(QueueDepth));
  assign in_fire = in_valid && !in_stall;
  // Cells outside the grid are consumed and dropped here.
  assign in_keep = (32'(in_cell_x) <= CoordMax) && (32'(in_cell_y) <= CoordMax) &&
                   (32'(in_cell_z) <= CoordMax);
  assign push = in_fire && in_keep;
  assign q_valid = (cnt_r != '0);
  assign q_head = q_mem_r[0];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) iso_r <= cfg_iso_level;
      cnt_r <= cnt_nxt;
    end
  end

  // Shift queue: entry 0 is the head.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      if (q_pop) begin
        if (push && (CntW'(i) == cnt_r - 1'b1)) q_mem_r[i] <= cls;
        else if (i < QueueDepth - 1) q_mem_r[i] <= q_mem_r[(i + 1) % QueueDepth];
      end else if (push && (CntW'(i) == cnt_r)) begin
        q_mem_r[i] <= cls;
      end
    end
  end

  `MTC_ASSERT_IMPL(a_no_overflow, clk, rst_n, 1'b1, cnt_r <= CntW'(QueueDepth))
  `MTC_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, q_pop, q_valid)
  `MTC_ASSERT_NEXT(a_cfg_held, clk, rst_n, cfg_we, iso_r == $past(cfg_iso_level))
endmodule

FILE: rtl/mtc_div.sv
`timescale 1ns / 1ps
module mtc_div
  import mtc_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DiffW-1:0]     num,
  input  logic [DiffW:0]       den,
  output logic                 done,
  output logic [FRAC_BITS:0]   t
);
  // Restoring divider, one quotient bit per cycle, clamped to 2^FRAC_BITS.
  localparam int QW = DiffW + FRAC_BITS;
  localparam int StepW = $clog2(QW + 1);
  localparam logic [FRAC_BITS:0] One = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic [QW-1:0]    q_r, q_nxt;
  logic [DiffW+1:0] rem_r, rem_nxt, trial;
  logic [DiffW:0]   den_r;
  logic [StepW-1:0] step_r;
  logic             busy_r;

  always_comb begin
    trial = {rem_r[DiffW:0], q_r[QW-1]};
    q_nxt = {q_r[QW-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        q_r <= {num, FRAC_BITS'(0)};
        rem_r <= '0;
        den_r <= den;
      end else if (busy_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == StepW'(QW - 1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign t = (q_r > QW'(One)) ? One : q_r[FRAC_BITS:0];
endmodule

FILE: rtl/mtc_back.sv
`timescale 1ns / 1ps
module mtc_back
  import mtc_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  cell_t                q_head,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0][2:0][OutW-1:0] out_vert,
  output logic                 out_last
);
  `include "marching_tetrahedra_cell_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TET  = 5'b00010,
    S_EDGE = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r;
  logic [2:0] tet_r, edge_r;
  logic [3:0] idx_r;
  logic [5:0] cuts_r;
  logic       tri_r;
  logic [5:0][2:0][OutW-1:0] pos_r;
  logic       pend_r;
  logic [2:0][2:0][OutW-1:0] pend_vert_r;
  logic       fin_r;

  logic [3:0][2:0] cv;
  logic [3:0] idx_c;
  logic [1:0] tcnt_c;
  logic [1:0][1:0] ee;
  logic [2:0] ca, cb, oa, ob;
  logic signed [DiffW-1:0] da, db;
  logic signed [DiffW:0] den_s;
  logic [DiffW-1:0] num_abs;
  logic [DiffW:0] den_abs;
  logic zero_t, div_start, div_done;
  logic [FRAC_BITS:0] div_t;
  logic [FRAC_BITS:0] tt;
  logic [2:0][OutW-1:0] vpos;
  logic [5:0][2:0] te;
  logic [2:0][2:0][OutW-1:0] tri_vert;
  logic out_free, last_tet, more_tri, emit_c;
  logic [2:0][CoordW-1:0] cell_xyz;

  assign cv = tet_corners(tet_r);
  assign cell_xyz = {q_head.z, q_head.y, q_head.x};
  always_comb begin
    for (int i = 0; i < 4; i++) idx_c[i] = q_head.neg[cv[i]];
  end
  // Once the sixth tetrahedron is done, only the held triangle is left to flush.
  assign tcnt_c = fin_r ? 2'd0 : tri_count(idx_c);

  assign ee = edge_ends(edge_r);
  assign ca = cv[ee[0]];
  assign cb = cv[ee[1]];
  assign oa = corner_off(ca);
  assign ob = corner_off(cb);
  assign da = q_head.d[ca];
  assign db = q_head.d[cb];
  assign den_s = (DiffW+1)'(da) - (DiffW+1)'(db);
  assign zero_t = (da == '0) || (den_s == '0) || (da[DiffW-1] != den_s[DiffW]);
  assign num_abs = da[DiffW-1] ? DiffW'(-da) : DiffW'(da);
  assign den_abs = den_s[DiffW] ? (DiffW+1)'(-den_s) : (DiffW+1)'(den_s);
  assign div_start = (state_r == S_EDGE) && (edge_r != 3'd6) && cuts_r[edge_r] && !zero_t;
  assign tt = (state_r == S_DIV) ? div_t : '0;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      vpos[ax] = OutW'({cell_xyz[ax] + CoordW'(oa[ax]), FRAC_BITS'(0)});
      if (ob[ax] && !oa[ax]) vpos[ax] = vpos[ax] + OutW'(tt);
      else if (!ob[ax] && oa[ax]) vpos[ax] = vpos[ax] - OutW'(tt);
    end
  end

  assign te = tri_edges(idx_r);
  always_comb begin
    for (int v = 0; v < 3; v++) tri_vert[v] = pos_r[te[3'({1'b0, tri_r} * 3 + v)]];
  end

  mtc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_abs), .den(den_abs),
    .done(div_done), .t(div_t)
  );

  assign out_free = !out_valid || !out_stall;
  assign last_tet = (tet_r == 3'd5);
  assign more_tri = (tri_count(idx_r) == 2'd2) && !tri_r;
  assign q_pop = (state_r == S_TET) && last_tet && (tcnt_c == 2'd0) &&
                 (!pend_r || out_free);
  assign emit_c = pend_r && out_free &&
                  (((state_r == S_TET) && last_tet && (tcnt_c == 2'd0)) ||
                   (state_r == S_EMIT));

  // A triangle is held back one slot so the cell's final one can be marked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      pend_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      if (emit_c) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            state_r <= S_TET;
            tet_r <= '0;
            fin_r <= 1'b0;
          end
        end
        S_TET: begin
          idx_r <= idx_c;
          cuts_r <= cut_edges(idx_c);
          tri_r <= 1'b0;
          edge_r <= '0;
          if (tcnt_c != 2'd0) begin
            state_r <= S_EDGE;
          end else if (last_tet) begin
            if (pend_r && out_free) begin
              out_vert <= pend_vert_r;
              out_last <= 1'b1;
              pend_r <= 1'b0;
              state_r <= S_IDLE;
            end else if (!pend_r) begin
              state_r <= S_IDLE;
            end
          end else begin
            tet_r <= tet_r + 1'b1;
          end
        end
        S_EDGE: begin
          if (edge_r == 3'd6) begin
            state_r <= S_EMIT;
          end else if (div_start) begin
            state_r <= S_DIV;
          end else begin
            if (cuts_r[edge_r]) pos_r[edge_r] <= vpos;
            edge_r <= edge_r + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pos_r[edge_r] <= vpos;
            edge_r <= edge_r + 1'b1;
            state_r <= S_EDGE;
          end
        end
        S_EMIT: begin
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_vert <= pend_vert_r;
              out_last <= 1'b0;
            end
            pend_r <= 1'b1;
            pend_vert_r <= tri_vert;
            if (more_tri) begin
              tri_r <= 1'b1;
            end else if (last_tet) begin
              fin_r <= 1'b1;
              state_r <= S_TET;
            end else begin
              tet_r <= tet_r + 1'b1;
              state_r <= S_TET;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MTC_ASSERT_IMPL(a_pop_idle_path, clk, rst_n, q_pop, state_r == S_TET)
  `MTC_ASSERT_IMPL(a_pend_emit, clk, rst_n, (state_r == S_IDLE), !pend_r)
  `MTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_vert) && $stable(out_last))
endmodule

FILE: rtl/marching_tetrahedra_cell.sv
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// cfg       cfg_we                   cfg_iso_level
// in        in_valid / in_stall      in_cell_x/y/z, in_corner_sample_0..7
// out       out_valid / out_stall    out_vert_{a,b,c}_{x,y,z}, out_last_triangle
// A cell is walked one tetrahedron at a time; each cut edge that needs a division goes
// through the one shared serial divider, and each triangle is emitted in turn; when the
// sixth tetrahedron has triangles, a further step marks the final triangle. The divider
// sets the pace, and out_stall on a waiting triangle holds the back. Reset is synchronous,
// active low, and sets iso_level to zero. A two-entry queue parts the front from the back,
// so input is taken while the back works or waits on out_stall, until the queue is full.
module marching_tetrahedra_cell
  import mtc_pkg::*;
#(
  parameter int GRID_SIZE = GridSizeDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic signed [SampleW-1:0] cfg_iso_level,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CoordW-1:0]         in_cell_x,
  input  logic [CoordW-1:0]         in_cell_y,
  input  logic [CoordW-1:0]         in_cell_z,
  input  logic signed [SampleW-1:0] in_corner_sample_0,
  input  logic signed [SampleW-1:0] in_corner_sample_1,
  input  logic signed [SampleW-1:0] in_corner_sample_2,
  input  logic signed [SampleW-1:0] in_corner_sample_3,
  input  logic signed [SampleW-1:0] in_corner_sample_4,
  input  logic signed [SampleW-1:0] in_corner_sample_5,
  input  logic signed [SampleW-1:0] in_corner_sample_6,
  input  logic signed [SampleW-1:0] in_corner_sample_7,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OutW-1:0]           out_vert_a_x,
  output logic [OutW-1:0]           out_vert_a_y,
  output logic [OutW-1:0]           out_vert_a_z,
  output logic [OutW-1:0]           out_vert_b_x,
  output logic [OutW-1:0]           out_vert_b_y,
  output logic [OutW-1:0]           out_vert_b_z,
  output logic [OutW-1:0]           out_vert_c_x,
  output logic [OutW-1:0]           out_vert_c_y,
  output logic [OutW-1:0]           out_vert_c_z,
  output logic                      out_last_triangle
);
  logic q_valid, q_pop;
  cell_t q_head;
  logic [2:0][2:0][OutW-1:0] vert;

  mtc_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_iso_level(cfg_iso_level),
    .in_valid(in_valid), .in_stall(in_stall), .in_cell_x(in_cell_x),
    .in_cell_y(in_cell_y), .in_cell_z(in_cell_z),
    .in_samples({in_corner_sample_7, in_corner_sample_6, in_corner_sample_5,
                 in_corner_sample_4, in_corner_sample_3, in_corner_sample_2,
                 in_corner_sample_1, in_corner_sample_0}),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  mtc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .out_valid(out_valid), .out_stall(out_stall), .out_vert(vert),
    .out_last(out_last_triangle)
  );

  assign out_vert_a_x = vert[0][0];
  assign out_vert_a_y = vert[0][1];
  assign out_vert_a_z = vert[0][2];
  assign out_vert_b_x = vert[1][0];
  assign out_vert_b_y = vert[1][1];
  assign out_vert_b_z = vert[1][2];
  assign out_vert_c_x = vert[2][0];
  assign out_vert_c_y = vert[2][1];
  assign out_vert_c_z = vert[2][2];
endmodule

FILE: verif/mtc_checker.sv
`timescale 1ns / 1ps
module mtc_checker
  import mtc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic signed [SampleW-1:0] cfg_iso_level,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [CoordW-1:0]         in_cell_x,
  input  logic [CoordW-1:0]         in_cell_y,
  input  logic [CoordW-1:0]         in_cell_z,
  input  logic [7:0][SampleW-1:0]   in_samples,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [8:0][OutW-1:0]      out_verts,
  input  logic                      out_last_triangle,
  output int                        error_count,
  output int                        pending_count
);
  typedef struct packed {
    logic [8:0][OutW-1:0] verts;
    logic                 last;
  } triangle_t;

  localparam int Frac = FracBitsDef;
  localparam int CellMax = GridSizeDef - 2;

  // Tetrahedron corners, edge ends, triangle tables and corner offsets.
  localparam logic [2:0] TetCorner [6][4] = '{
    '{0, 3, 1, 5}, '{1, 3, 2, 5}, '{4, 5, 7, 3},
    '{5, 6, 7, 3}, '{0, 5, 4, 3}, '{5, 2, 6, 3}};
  localparam logic [1:0] EdgeEnd [6][2] = '{
    '{0, 1}, '{1, 2}, '{2, 0}, '{0, 3}, '{1, 3}, '{2, 3}};
  localparam logic [5:0] CutMask [16] = '{
    6'h00, 6'h0D, 6'h13, 6'h1E, 6'h26, 6'h2B, 6'h35, 6'h38,
    6'h38, 6'h35, 6'h2B, 6'h26, 6'h1E, 6'h13, 6'h0D, 6'h00};
  localparam int TriNum [16] = '{0, 1, 1, 2, 1, 2, 2, 1, 1, 2, 2, 1, 2, 1, 1, 0};
  localparam logic [2:0] TriEdge [16][6] = '{
    '{0, 0, 0, 0, 0, 0}, '{0, 3, 2, 0, 0, 0}, '{0, 1, 4, 0, 0, 0}, '{1, 4, 3, 1, 3, 2},
    '{1, 2, 5, 0, 0, 0}, '{1, 3, 5, 1, 0, 3}, '{2, 5, 4, 2, 4, 0}, '{3, 5, 4, 0, 0, 0},
    '{3, 4, 5, 0, 0, 0}, '{2, 4, 5, 2, 0, 4}, '{1, 5, 3, 1, 3, 0}, '{1, 5, 2, 0, 0, 0},
    '{1, 3, 4, 1, 2, 3}, '{0, 4, 1, 0, 0, 0}, '{0, 2, 3, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}};
  localparam logic [2:0] CornerOff [8][3] = '{
    '{0, 0, 0}, '{1, 0, 0}, '{1, 1, 0}, '{0, 1, 0},
    '{0, 0, 1}, '{1, 0, 1}, '{1, 1, 1}, '{0, 1, 1}};

  logic signed [SampleW-1:0] iso_level;
  triangle_t expected_triangles[$];

  assign pending_count = expected_triangles.size();

  function automatic string vert_name(int i);
    case (i)
      0: return "vert_a_x";
      1: return "vert_a_y";
      2: return "vert_a_z";
      3: return "vert_b_x";
      4: return "vert_b_y";
      5: return "vert_b_z";
      6: return "vert_c_x";
      7: return "vert_c_y";
      default: return "vert_c_z";
    endcase
  endfunction

  function automatic int crossing_fraction(int da, int db);
    longint den, num, q;
    den = da - db;
    if (da == 0 || den == 0) return 0;
    if ((da < 0) != (den < 0)) return 0;
    num = (da < 0 ? -longint'(da) : longint'(da)) <<< Frac;
    q = num / (den < 0 ? -den : den);
    return (q > (1 << Frac)) ? (1 << Frac) : int'(q);
  endfunction

  task automatic predict_triangles(input logic [2:0][CoordW-1:0] cell_xyz,
                                   input logic [7:0][SampleW-1:0] samples);
    int diff [8];
    int pos [6][3];
    int base, tt, idx, n, first, a, b;
    logic [5:0] edges;
    triangle_t tri_item;
    first = expected_triangles.size();
    n = 0;
    for (int ax = 0; ax < 3; ax++)
      if (cell_xyz[ax] > CellMax) return;
    for (int i = 0; i < 8; i++)
      diff[i] = int'($signed(samples[i])) - int'(iso_level);
    for (int t = 0; t < 6; t++) begin
      idx = 0;
      for (int i = 0; i < 4; i++)
        if (diff[TetCorner[t][i]] < 0) idx |= 1 << i;
      edges = CutMask[idx];
      for (int e = 0; e < 6; e++) begin
        for (int ax = 0; ax < 3; ax++) pos[e][ax] = 0;
        if (edges[e]) begin
          a = TetCorner[t][EdgeEnd[e][0]];
          b = TetCorner[t][EdgeEnd[e][1]];
          tt = crossing_fraction(diff[a], diff[b]);
          for (int ax = 0; ax < 3; ax++) begin
            base = (int'(cell_xyz[ax]) + CornerOff[a][ax]) << Frac;
            if (CornerOff[b][ax] > CornerOff[a][ax]) base += tt;
            else if (CornerOff[b][ax] < CornerOff[a][ax]) base -= tt;
            pos[e][ax] = base;
          end
        end
      end
      for (int k = 0; k < TriNum[idx]; k++) begin
        for (int i = 0; i < 3; i++)
          for (int ax = 0; ax < 3; ax++)
            tri_item.verts[i * 3 + ax] = OutW'(pos[TriEdge[idx][k * 3 + i]][ax]);
        tri_item.last = 1'b0;
        expected_triangles.push_back(tri_item);
        n++;
      end
    end
    if (n > 0) expected_triangles[first + n - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    triangle_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      iso_level <= '0;
      error_count <= 0;
    end else begin
      if (cfg_we) iso_level <= cfg_iso_level;
      if (in_valid && !in_stall)
        predict_triangles({in_cell_z, in_cell_y, in_cell_x}, in_samples);
      if (out_valid && !out_stall) begin
        if (expected_triangles.size() == 0) begin
          $error("unexpected triangle transfer");
          errs++;
        end else begin
          want = expected_triangles.pop_front();
          for (int i = 0; i < 9; i++)
            if (want.verts[i] !== out_verts[i]) begin
              $error("%s: expected %0d, got %0d", vert_name(i), want.verts[i],
                     out_verts[i]);
              errs++;
            end
          if (want.last !== out_last_triangle) begin
            $error("last_triangle: expected %0d, got %0d", want.last, out_last_triangle);
            errs++;
          end
        end
      end
      error_count <= error_count + errs;
    end
  end
endmodule

FILE: verif/tb_marching_tetrahedra_cell.sv
`timescale 1ns / 1ps
module tb_marching_tetrahedra_cell;
  import mtc_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int RandomCells = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic signed [SampleW-1:0] cfg_iso_level = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CoordW-1:0] in_cell_x = '0, in_cell_y = '0, in_cell_z = '0;
  logic [7:0][SampleW-1:0] in_samples = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [8:0][OutW-1:0] out_verts;
  logic out_last_triangle;
  int error_count, pending_count;
  int idle_cycles;
  bit quiet_mode = 1'b0;
  int level_set [5] = '{-32768, 32767, 1234, -777, 0};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  marching_tetrahedra_cell dut (
    .clk, .rst_n, .cfg_we, .cfg_iso_level, .in_valid, .in_stall,
    .in_cell_x, .in_cell_y, .in_cell_z,
    .in_corner_sample_0(in_samples[0]), .in_corner_sample_1(in_samples[1]),
    .in_corner_sample_2(in_samples[2]), .in_corner_sample_3(in_samples[3]),
    .in_corner_sample_4(in_samples[4]), .in_corner_sample_5(in_samples[5]),
    .in_corner_sample_6(in_samples[6]), .in_corner_sample_7(in_samples[7]),
    .out_valid, .out_stall,
    .out_vert_a_x(out_verts[0]), .out_vert_a_y(out_verts[1]), .out_vert_a_z(out_verts[2]),
    .out_vert_b_x(out_verts[3]), .out_vert_b_y(out_verts[4]), .out_vert_b_z(out_verts[5]),
    .out_vert_c_x(out_verts[6]), .out_vert_c_y(out_verts[7]), .out_vert_c_z(out_verts[8]),
    .out_last_triangle
  );

  mtc_checker checker_i (
    .clk, .rst_n, .cfg_we, .cfg_iso_level, .in_valid, .in_stall,
    .in_cell_x, .in_cell_y, .in_cell_z, .in_samples,
    .out_valid, .out_stall, .out_verts, .out_last_triangle,
    .error_count, .pending_count
  );

  // Receiver stalls come in bursts; a new burst is drawn once one ends.
  always @(posedge clk) begin
    int burst;
    if (!rst_n || quiet_mode) begin
      out_stall <= 1'b0;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
    end else begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(1, 16) : 0;
      out_stall <= burst != 0;
      idle_cycles <= (burst > 0) ? burst - 1 : 0;
    end
  end

  // Watchdog: any stretch without a transfer that grows too long is a hang.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Valid stays high from one cell to the next unless an idle gap is drawn.
  task automatic send_cell(input logic [5:0] x, y, z, input logic [7:0][SampleW-1:0] s);
    int gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_x <= x;
    in_cell_y <= y;
    in_cell_z <= z;
    in_samples <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_iso(input logic signed [SampleW-1:0] level);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_iso_level <= level;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [5:0] random_coord();
    case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return 6'd62;
      2: return 6'd63;
      default: return 6'($urandom_range(0, 62));
    endcase
  endfunction

  // Samples near the iso level cut many edges; full-range samples hit extremes.
  function automatic logic [7:0][SampleW-1:0] random_samples(int level);
    logic [7:0][SampleW-1:0] s;
    int v;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 5))
        0: v = $urandom_range(0, 1) ? 32767 : -32768;
        1: v = level;
        2: v = int'($urandom) >>> 16;
        default: v = level + int'($urandom_range(0, 600)) - 300;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      s[i] = SampleW'(v);
    end
    return s;
  endfunction

  initial begin
    logic [7:0][SampleW-1:0] s;
    int level;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: uniform cells, every single-corner sign pattern, extremes, samples
    // equal to the iso level (zero numerator), and cells outside the grid.
    send_cell(6'd0, 6'd0, 6'd0, {8{16'sd100}});
    send_cell(6'd0, 6'd0, 6'd0, {8{-16'sd100}});
    for (int c = 0; c < 8; c++) begin
      s = {8{16'sd200}};
      s[c] = -16'sd56;
      send_cell(6'(c * 7), 6'(62 - c), 6'(c), s);
    end
    send_cell(6'd62, 6'd62, 6'd62, {{4{16'h7FFF}}, {4{16'h8000}}});
    send_cell(6'd0, 6'd62, 6'd0, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                  16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    send_cell(6'd63, 6'd0, 6'd0, {{4{16'h7FFF}}, {4{16'h8000}}});
    send_cell(6'd0, 6'd63, 6'd0, {{4{16'h7FFF}}, {4{16'h8000}}});
    send_cell(6'd0, 6'd0, 6'd63, {{4{16'h7FFF}}, {4{16'h8000}}});
    send_cell(6'd5, 6'd5, 6'd5,
              {16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0});
    send_cell(6'd1, 6'd2, 6'd3,
              {-16'sd5, 16'sd7, -16'sd3, 16'sd0, 16'sd1, -16'sd9, 16'sd4, 16'sd0});

    // Let the block drain completely before going on.
    drain_and_settle();

    foreach (level_set[j]) begin
      write_iso(SampleW'(level_set[j]));
      for (int i = 0; i < RandomCells / 5; i++) begin
        if (j == 4 && i == RandomCells / 10) quiet_mode = 1'b1;
        send_cell(random_coord(), random_coord(), random_coord(),
                  random_samples(level_set[j]));
      end
    end

    drain_and_settle();
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
